/* sv/qpe_pkg.sv */
// Shared types, character constants and small helper functions for the
// quoted-printable encoder. No dependencies; every module imports it.
package qpe_pkg;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_DEL = 8'h7F;

    localparam logic [7:0] LIMIT_RESET = 8'd75;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic [1:0] op_kind_t;
    localparam op_kind_t OP_COPY  = 2'd0;
    localparam op_kind_t OP_QUOTE = 2'd1;
    localparam op_kind_t OP_CRLF  = 2'd2;

    // One unit of work for the back end: a byte to copy, a byte to quote,
    // or a hard line break.
    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  data;
        logic        tail;
        logic        msg_end;
    } qpe_op_t;

    function automatic logic needs_quote(input logic [7:0] c, input logic next_cr);
        return (c < CHAR_SP) || (c >= CHAR_DEL) || (c == CHAR_EQ) ||
               ((c == CHAR_SP) && next_cr);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] wide;
        wide = {4'b0000, n};
        return (n < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

    function automatic logic [2:0] body_len(input op_kind_t kind);
        logic [2:0] len;
        unique case (kind)
            OP_QUOTE: len = 3'd3;
            OP_CRLF:  len = 3'd2;
            default:  len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] body_char(input op_kind_t kind,
                                             input logic [7:0] data,
                                             input logic [2:0] j);
        logic [7:0] ch;
        unique case (kind)
            OP_QUOTE:
            begin
                if (j == 3'd0)
                    ch = CHAR_EQ;
                else if (j == 3'd1)
                    ch = hex_char(data[7:4]);
                else
                    ch = hex_char(data[3:0]);
            end
            OP_CRLF:  ch = (j == 3'd0) ? CHAR_CR : CHAR_LF;
            default:  ch = data;
        endcase
        return ch;
    endfunction

endpackage

/* sv/qpe_if.sv */
// Handshake channels of the quoted-printable encoder: raw items in,
// encoded characters out, and the line limit write port.
interface qpe_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface qpe_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
    modport source (output valid, output out_byte, output run_last,
                    output message_end, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input message_end, output ready);
endinterface

interface qpe_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_limit;
    modport source (output valid, output line_limit, input ready);
    modport sink   (input valid, input line_limit, output ready);
endinterface

/* sv/quoted_printable_encoder.sv */
// Quoted-printable encoder. Bytes enter on the item channel and leave as
// encoded characters on the result channel, one per cycle unless it stalls.
// The encoder keeps one byte back to recognize CR LF pairs and a space before
// a CR, so the characters for a byte appear only after the next byte (or the
// in_last byte) has been transferred. The output port moves one character a
// cycle, which sets the rate: a copied byte gives one character, a quoted
// byte three, a CR LF pair two, and a soft break adds three. A four-entry
// operation queue lets input transfers continue while the output is stalled.
// The line limit may be written at any time the encoder is idle; it resets
// to 75. Depends on qpe_pkg, qpe_if, qpe_front, qpe_queue and qpe_back.
module quoted_printable_encoder
    import qpe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    qpe_item_if.sink     item,
    qpe_result_if.source result,
    qpe_cfg_if.sink      cfg
);

    logic    push;
    qpe_op_t push_op;
    logic    pop;
    qpe_op_t head_op;
    logic    q_full;
    logic    q_empty;

    qpe_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_full  (q_full),
        .push    (push),
        .push_op (push_op)
    );

    qpe_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    qpe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .result  (result),
        .head_op (head_op),
        .q_empty (q_empty),
        .pop     (pop)
    );

endmodule

/* sv/qpe_queue.sv */
// Four-entry register queue of encoder operations between front and back.
// Depends on qpe_pkg for the operation type and depth.
module qpe_queue
    import qpe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  qpe_op_t push_op,
    input  logic    pop,
    output qpe_op_t head_op,
    output logic    full,
    output logic    empty
);

    qpe_op_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* sv/qpe_front.sv */
// Front end: holds one byte of lookahead, spots CR LF pairs and bytes that
// need quoting, and pushes operations into the queue. Uses qpe_pkg, qpe_if.
module qpe_front
    import qpe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    qpe_item_if.sink     item,
    input  logic         q_full,
    output logic         push,
    output qpe_op_t      push_op
);

    logic       held_valid_reg;
    logic [7:0] held_byte_reg;
    logic       pend_valid_reg;
    qpe_op_t    pend_op_reg;

    logic    accept;
    logic    is_crlf;
    logic    op1_valid;
    logic    op2_valid;
    qpe_op_t held_op;
    qpe_op_t new_op;
    qpe_op_t crlf_op;
    qpe_op_t op1;

    assign item.ready = !pend_valid_reg && !q_full;
    assign accept     = item.valid && item.ready;

    assign is_crlf = held_valid_reg && (held_byte_reg == CHAR_CR) &&
                     (item.in_byte == CHAR_LF);

    always_comb
    begin
        held_op.kind    = needs_quote(held_byte_reg, item.in_byte == CHAR_CR) ?
                          OP_QUOTE : OP_COPY;
        held_op.data    = held_byte_reg;
        held_op.tail    = !item.in_last;
        held_op.msg_end = 1'b0;

        // The final byte of a message has no lookahead: a trailing space stays plain.
        new_op.kind     = needs_quote(item.in_byte, 1'b0) ? OP_QUOTE : OP_COPY;
        new_op.data     = item.in_byte;
        new_op.tail     = 1'b1;
        new_op.msg_end  = 1'b1;

        crlf_op.kind    = OP_CRLF;
        crlf_op.data    = CHAR_CR;
        crlf_op.tail    = 1'b1;
        crlf_op.msg_end = item.in_last;

        if (is_crlf)
            op1 = crlf_op;
        else if (held_valid_reg)
            op1 = held_op;
        else
            op1 = new_op;
    end

    assign op1_valid = accept && (held_valid_reg || item.in_last);
    assign op2_valid = accept && held_valid_reg && !is_crlf && item.in_last;

    // A second operation from the same transfer waits in pend_op_reg until the queue has room.
    assign push    = pend_valid_reg ? !q_full : op1_valid;
    assign push_op = pend_valid_reg ? pend_op_reg : op1;

    always_ff @(posedge clk)
    begin
        if (accept)
            held_byte_reg <= item.in_byte;
        if (op2_valid)
            pend_op_reg <= new_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                held_valid_reg <= !(is_crlf || item.in_last);
            if (op2_valid)
                pend_valid_reg <= 1'b1;
            else if (pend_valid_reg && !q_full)
                pend_valid_reg <= 1'b0;
        end
    end

endmodule

/* sv/qpe_back.sv */
// Back end: tracks the line position, decides soft breaks, and spells out
// each operation into the output register, one character per cycle unless
// the result channel stalls. Uses qpe_pkg and qpe_if.
module qpe_back
    import qpe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    qpe_cfg_if.sink      cfg,
    qpe_result_if.source result,
    input  qpe_op_t      head_op,
    input  logic         q_empty,
    output logic         pop
);

    logic [7:0] limit_reg;
    logic [7:0] pos_reg;
    logic [7:0] pos_next;

    logic       cur_valid_reg;
    op_kind_t   cur_kind_reg;
    logic [7:0] cur_data_reg;
    logic       cur_soft_reg;
    logic [2:0] cur_idx_reg;
    logic [2:0] cur_len_reg;
    logic       cur_tail_reg;
    logic       cur_end_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_run_last_reg;
    logic       out_msg_end_reg;

    logic       emit;
    logic       last_char;
    logic       soft_break;
    logic [8:0] sum1;
    logic [8:0] sum3;
    logic [8:0] limit9;
    logic [2:0] body_idx;
    logic [7:0] char_sel;

    assign cfg.ready = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.run_last    = out_run_last_reg;
    assign result.message_end = out_msg_end_reg;

    assign emit      = cur_valid_reg && (!out_valid_reg || result.ready);
    assign last_char = (cur_idx_reg == cur_len_reg - 3'd1);
    assign pop       = !q_empty && (!cur_valid_reg || (emit && last_char));

    assign sum1   = {1'b0, pos_reg} + 9'd1;
    assign sum3   = {1'b0, pos_reg} + 9'd3;
    assign limit9 = {1'b0, limit_reg};

    always_comb
    begin
        soft_break = ((head_op.kind == OP_QUOTE) && (sum3 > limit9)) ||
                     ((head_op.kind == OP_COPY) && (sum1 > limit9));
        if (head_op.msg_end || head_op.kind == OP_CRLF)
            pos_next = '0;
        else if (head_op.kind == OP_QUOTE)
            pos_next = soft_break ? 8'd3 : sum3[7:0];
        else
            pos_next = soft_break ? 8'd1 : sum1[7:0];
    end

    // A soft break occupies the first three characters of the sequence.
    always_comb
    begin
        body_idx = cur_soft_reg ? (cur_idx_reg - 3'd3) : cur_idx_reg;
        if (cur_soft_reg && cur_idx_reg < 3'd3)
        begin
            if (cur_idx_reg == 3'd0)
                char_sel = CHAR_EQ;
            else if (cur_idx_reg == 3'd1)
                char_sel = CHAR_CR;
            else
                char_sel = CHAR_LF;
        end
        else
            char_sel = body_char(cur_kind_reg, cur_data_reg, body_idx);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_kind_reg <= head_op.kind;
            cur_data_reg <= head_op.data;
            cur_soft_reg <= soft_break;
            cur_len_reg  <= body_len(head_op.kind) + (soft_break ? 3'd3 : 3'd0);
            cur_tail_reg <= head_op.tail;
            cur_end_reg  <= head_op.msg_end;
        end
        if (emit)
        begin
            out_byte_reg     <= char_sel;
            out_run_last_reg <= cur_tail_reg && last_char;
            out_msg_end_reg  <= cur_end_reg && last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            pos_reg       <= '0;
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                limit_reg <= cfg.line_limit;
            if (pop)
            begin
                pos_reg       <= pos_next;
                cur_valid_reg <= 1'b1;
                cur_idx_reg   <= '0;
            end
            else if (emit)
            begin
                if (last_char)
                    cur_valid_reg <= 1'b0;
                cur_idx_reg <= cur_idx_reg + 3'd1;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

/* sim/qpe_output_check.sv */
// Watches the item, result and line limit channels of the quoted-printable
// encoder, predicts each encoded character and compares it on transfer.
// Depends on qpe_pkg and qpe_if.
module qpe_output_check
    import qpe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    qpe_item_if    item,
    qpe_result_if  result,
    qpe_cfg_if     cfg,
    output int     char_errors,
    output int     chars_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } qp_char_t;

    qp_char_t   expected_chars[$];
    qp_char_t   step_chars[$];
    logic [7:0] limit_reg;
    logic       la_valid;
    logic [7:0] la_byte;
    int         line_pos;
    int         mismatches;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] v;
        v = {4'd0, n};
        if (n < 4'd10)
            return 8'h30 + v;
        return 8'h41 + v - 8'd10;
    endfunction

    task automatic put_char(input logic [7:0] c);
        qp_char_t e;
        e.ch       = c;
        e.run_last = 1'b0;
        e.msg_end  = 1'b0;
        step_chars.push_back(e);
    endtask

    // One byte of the message: either copied or written as =XY, with a soft
    // break first when it would not fit on the current line.
    task automatic encode_char(input logic [7:0] c, input logic next_cr);
        logic quote;
        int   width;
        quote = (c < CHAR_SP) || (c >= CHAR_DEL) || (c == CHAR_EQ) ||
                ((c == CHAR_SP) && next_cr);
        width = quote ? 3 : 1;
        if (line_pos + width > int'(limit_reg))
        begin
            put_char(CHAR_EQ);
            put_char(CHAR_CR);
            put_char(CHAR_LF);
            line_pos = 0;
        end
        line_pos = line_pos + width;
        if (quote)
        begin
            put_char(CHAR_EQ);
            put_char(hex_digit(c[7:4]));
            put_char(hex_digit(c[3:0]));
        end
        else
        begin
            put_char(c);
        end
    endtask

    task automatic predict_item(input logic [7:0] b, input logic last);
        qp_char_t e;
        step_chars.delete();
        if (la_valid)
        begin
            if (la_byte == CHAR_CR && b == CHAR_LF)
            begin
                put_char(CHAR_CR);
                put_char(CHAR_LF);
                line_pos = 0;
                la_valid = 1'b0;
            end
            else
            begin
                encode_char(la_byte, b == CHAR_CR);
                if (last)
                begin
                    encode_char(b, 1'b0);
                    la_valid = 1'b0;
                end
                else
                begin
                    la_byte = b;
                end
            end
        end
        else if (last)
        begin
            encode_char(b, 1'b0);
        end
        else
        begin
            la_valid = 1'b1;
            la_byte  = b;
        end

        if (step_chars.size() > 0)
        begin
            e = step_chars.pop_back();
            e.run_last = 1'b1;
            e.msg_end  = last;
            step_chars.push_back(e);
        end
        while (step_chars.size() > 0)
            expected_chars.push_back(step_chars.pop_front());

        if (last)
        begin
            la_valid = 1'b0;
            la_byte  = 8'd0;
            line_pos = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        qp_char_t e;
        if (!rst_n)
        begin
            expected_chars.delete();
            limit_reg  = LIMIT_RESET;
            la_valid   = 1'b0;
            la_byte    = 8'd0;
            line_pos   = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                limit_reg = cfg.line_limit;

            if (item.valid && item.ready)
                predict_item(item.in_byte, item.in_last);

            if (result.valid && result.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected character %h run_last=%b message_end=%b",
                                 $realtime, result.out_byte, result.run_last,
                                 result.message_end);
                end
                else
                begin
                    e = expected_chars.pop_front();
                    if (result.out_byte !== e.ch || result.run_last !== e.run_last ||
                        result.message_end !== e.msg_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected %h/%b/%b, got %h/%b/%b", $realtime,
                                     e.ch, e.run_last, e.msg_end, result.out_byte,
                                     result.run_last, result.message_end);
                    end
                end
            end
        end
        char_errors       <= mismatches;
        chars_outstanding <= expected_chars.size();
    end

endmodule

/* sim/quoted_printable_encoder_tb.sv */
// Top of the quoted-printable encoder testbench: clock, reset, stimulus,
// receiver back-pressure and the verdict. Depends on qpe_pkg, qpe_if,
// quoted_printable_encoder and qpe_output_check.
module quoted_printable_encoder_tb;
    import qpe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 55;

    logic clk = 1'b0;
    logic rst_n;

    qpe_item_if   item_ch ();
    qpe_result_if res_ch ();
    qpe_cfg_if    cfg_ch ();

    int char_errors;
    int chars_outstanding;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int quiet_cycles  = 0;
    int phase_items;

    quoted_printable_encoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    qpe_output_check out_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .item              (item_ch),
        .result            (res_ch),
        .cfg               (cfg_ch),
        .char_errors       (char_errors),
        .chars_outstanding (chars_outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Valid is left high after a transfer; the next call either offers the
    // next byte or drops valid in that same time step.
    task automatic offer_byte(input logic [7:0] b, input logic last);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.in_byte <= b;
        item_ch.in_last <= last;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        phase_items++;
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (chars_outstanding != 0)
            @(posedge clk);
    endtask

    // A held byte produces nothing yet, so the encoder may still be busy
    // after the last expected character; let it settle before writing.
    task automatic write_limit(input logic [7:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.line_limit <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_message(input int len);
        logic [7:0] body[$];
        int         pick;
        while (body.size() < len)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                body.push_back(8'($urandom_range(8'h21, 8'h7E)));
            else if (pick < 50)
                body.push_back(CHAR_SP);
            else if (pick < 62)
            begin
                body.push_back(CHAR_CR);
                body.push_back(CHAR_LF);
            end
            else if (pick < 66)
                body.push_back(CHAR_CR);
            else if (pick < 70)
                body.push_back(CHAR_LF);
            else if (pick < 74)
                body.push_back(CHAR_EQ);
            else if (pick < 78)
            begin
                body.push_back(CHAR_SP);
                body.push_back(CHAR_CR);
            end
            else if (pick < 88)
                body.push_back(8'($urandom_range(8'h80, 8'hFF)));
            else
                body.push_back(8'($urandom_range(0, 255)));
        end
        for (int k = 0; k < body.size(); k++)
            offer_byte(body[k], k == body.size() - 1);
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$]);
        for (int k = 0; k < bytes.size(); k++)
            offer_byte(bytes[k], k == bytes.size() - 1);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
                res_ch.ready <= 1'b0;
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int         mode;
        int         len;
        logic [7:0] lim;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.in_byte   = 8'd0;
        item_ch.in_last   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.line_limit = 8'd0;
        phase_items       = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit: a one-byte message, the quoting
        // classes, space before CR, CR LF, a lone CR before a letter, a
        // trailing space, a trailing lone CR, and a CR LF that ends a message.
        send_bytes('{8'h41});
        send_bytes('{8'h00, 8'hFF, CHAR_EQ, CHAR_DEL, CHAR_SP, CHAR_CR, CHAR_LF,
                     8'h09, CHAR_CR, 8'h41, CHAR_SP});
        send_bytes('{8'h7E, CHAR_CR});
        send_bytes('{CHAR_SP, CHAR_CR, CHAR_CR, CHAR_LF});

        // Lowest limit: every quoted byte needs a line of its own.
        write_limit(8'd3);
        send_bytes('{8'h61, 8'h62, CHAR_EQ, 8'h63});

        // The limit changes while a byte is held back.
        offer_byte(8'h71, 1'b0);
        write_limit(8'd252);
        offer_byte(8'h72, 1'b1);

        for (int ph = 0; ph < 8; ph++)
        begin
            mode = ph % 4;
            idle_pct  = (mode == 1) ? 47 : (mode == 3) ? 37 : 0;
            stall_pct = (mode == 2) ? 47 : (mode == 3) ? 37 : 0;
            if (ph == 0)
                lim = 8'd252;
            else if (ph == 1)
                lim = 8'd3;
            else if ($urandom_range(1) == 0)
                lim = 8'($urandom_range(3, 12));
            else
                lim = 8'($urandom_range(3, 252));
            write_limit(lim);
            if (ph == 4)
                hold_requests++;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (ph == 5 && phase_items >= PHASE_ITEMS / 2 &&
                    phase_items < PHASE_ITEMS / 2 + 8)
                begin
                    wait_drained();
                    phase_items = PHASE_ITEMS / 2 + 8;
                end
                if ($urandom_range(9) == 0)
                    len = $urandom_range(60, 140);
                else
                    len = $urandom_range(1, 24);
                // Keep each phase close to its share of the item budget.
                if (len > PHASE_ITEMS - phase_items)
                    len = PHASE_ITEMS - phase_items;
                if (len > 0)
                    send_message(len);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (char_errors == 0 && chars_outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
